@@ sv/pia_pkg.sv @@
// Shared types and constants for the primitive index assembler.
`timescale 1ns / 1ps
`default_nettype none

package pia_pkg;

	// Topology register codes
	localparam logic [2:0] TOPO_LINE_LIST = 3'd0;
	localparam logic [2:0] TOPO_LINE_STRIP = 3'd1;
	localparam logic [2:0] TOPO_LINE_LOOP = 3'd2;
	localparam logic [2:0] TOPO_TRI_LIST = 3'd3;
	localparam logic [2:0] TOPO_TRI_STRIP = 3'd4;
	localparam logic [2:0] TOPO_TRI_FAN = 3'd5;

	// Register byte addresses
	localparam logic [2:0] ADDR_TOPOLOGY = 3'd0;

	// Output queue depth (two slots free per accepted index)
	localparam int QDEPTH = 4;

	// One assembled primitive
	typedef struct packed {
		logic        run_last;
		logic        closing_line;
		logic [31:0] vert_third;
		logic [31:0] vert_second;
		logic [31:0] vert_first;
	} result_t;

endpackage

`default_nettype wire

@@ sv/primitive_index_assembler_unit.sv @@
// Top level of the primitive index assembler: state, topology register, output queue.
`timescale 1ns / 1ps
`default_nettype none

// Primitive index assembler. Accepts one vertex index per cycle on the s_axis
// side (tlast marks the end of a primitive group) and emits line or triangle
// index tuples on the m_axis side according to the topology register at byte
// address 0 (0 line list, 1 line strip, 2 line loop, 3 triangle list,
// 4 triangle strip, 5 triangle fan). Each index is assembled in the cycle it
// is accepted and yields zero, one or two results, which enter a four-entry
// output queue; the input is ready whenever two queue slots are free. The
// input rate is one index per cycle while that holds; the output drains one
// result per cycle while m_axis_tready is high, so a line loop group end, which
// emits two results, costs one extra output beat. Results are registered in the queue.
module primitive_index_assembler_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	// Index input
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [31:0]  s_axis_tdata,  // [31:0] index_value
	input  wire logic         s_axis_tlast,  // group_end
	// Primitive output
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic      [95:0]  m_axis_tdata,  // [31:0] vert_first, [63:32] vert_second,
	                                         // [95:64] vert_third
	output logic              m_axis_tuser,  // closing_line
	output logic              m_axis_tlast   // run_last
);
	import pia_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	// Registers
	logic [2:0]  topology_q;
	logic [31:0] group_first_q, previous_q, older_q;
	logic [1:0]  seen_q, phase_q;
	logic        parity_q;
	result_t     fifo_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	// Next-state and results
	logic [31:0] group_first_d, previous_d, older_d;
	logic [1:0]  seen_d, phase_d;
	logic        parity_d;
	result_t     res0, res1;
	logic [1:0]  n_res;

	logic [31:0] v;
	logic        last, accept, pop, cfg_wr;

	assign v      = s_axis_tdata;
	assign last   = s_axis_tlast;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign pop    = m_axis_tvalid && m_axis_tready;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == ADDR_TOPOLOGY) ? {29'd0, topology_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topology_q <= TOPO_TRI_LIST;
		end else if (cfg_wr && paddr == ADDR_TOPOLOGY) begin
			topology_q <= pwdata[2:0];
		end
	end

	// Assembly for one index
	always_comb begin
		group_first_d = group_first_q;
		previous_d    = previous_q;
		older_d       = older_q;
		seen_d        = seen_q;
		phase_d       = phase_q;
		parity_d      = parity_q;
		res0          = '0;
		res1          = '0;
		n_res         = 2'd0;

		unique case (topology_q)
			TOPO_LINE_LIST: begin
				if (phase_q != 2'd0) begin
					res0.vert_first  = previous_q;
					res0.vert_second = v;
					n_res            = 2'd1;
					phase_d          = 2'd0;
				end else begin
					previous_d = v;
					phase_d    = 2'd1;
				end
			end
			TOPO_LINE_STRIP, TOPO_LINE_LOOP: begin
				if (seen_q == 2'd0) begin
					group_first_d = v;
				end else begin
					res0.vert_first  = previous_q;
					res0.vert_second = v;
					n_res            = 2'd1;
				end
				// closing segment back to the group's first index
				if (topology_q == TOPO_LINE_LOOP && last && seen_q != 2'd0) begin
					res1.vert_first   = v;
					res1.vert_second  = group_first_q;
					res1.closing_line = 1'b1;
					n_res             = 2'd2;
				end
				older_d    = previous_q;
				previous_d = v;
			end
			TOPO_TRI_LIST: begin
				unique case (phase_q)
					2'd0: begin
						older_d = v;
						phase_d = 2'd1;
					end
					2'd1: begin
						previous_d = v;
						phase_d    = 2'd2;
					end
					default: begin
						res0.vert_first  = previous_q;
						res0.vert_second = older_q;
						res0.vert_third  = v;
						n_res            = 2'd1;
						phase_d          = 2'd0;
					end
				endcase
			end
			TOPO_TRI_STRIP: begin
				if (seen_q >= 2'd2) begin
					res0.vert_first  = parity_q ? older_q : previous_q;
					res0.vert_second = parity_q ? previous_q : older_q;
					res0.vert_third  = v;
					n_res            = 2'd1;
					parity_d         = ~parity_q;
				end
				if (seen_q == 2'd0) begin
					group_first_d = v;
				end
				older_d    = previous_q;
				previous_d = v;
			end
			TOPO_TRI_FAN: begin
				if (seen_q == 2'd0) begin
					group_first_d = v;
				end else if (seen_q >= 2'd2) begin
					res0.vert_first  = previous_q;
					res0.vert_second = group_first_q;
					res0.vert_third  = v;
					n_res            = 2'd1;
				end
				older_d    = previous_q;
				previous_d = v;
			end
			default: begin
			end
		endcase

		// group counter saturates at three; unused codes leave it alone
		if (topology_q <= TOPO_TRI_FAN && seen_q != 2'd3) begin
			seen_d = seen_q + 2'd1;
		end

		if (last) begin
			seen_d   = 2'd0;
			phase_d  = 2'd0;
			parity_d = 1'b0;
		end

		// flag the last result of this index
		if (n_res == 2'd2) begin
			res1.run_last = 1'b1;
		end else begin
			res0.run_last = 1'b1;
		end
	end

	// Assembly state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_first_q <= '0;
			previous_q    <= '0;
			older_q       <= '0;
			seen_q        <= '0;
			phase_q       <= '0;
			parity_q      <= 1'b0;
		end else if (accept) begin
			group_first_q <= group_first_d;
			previous_q    <= previous_d;
			older_q       <= older_d;
			seen_q        <= seen_d;
			phase_q       <= phase_d;
			parity_q      <= parity_d;
		end
	end

	// Output queue: ready while two slots are free
	assign s_axis_tready = (count_q <= (PW+1)'(QDEPTH - 2));
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = {fifo_q[rd_ptr_q].vert_third, fifo_q[rd_ptr_q].vert_second,
		fifo_q[rd_ptr_q].vert_first};
	assign m_axis_tuser  = fifo_q[rd_ptr_q].closing_line;
	assign m_axis_tlast  = fifo_q[rd_ptr_q].run_last;

	// Queue payload
	always_ff @(posedge clk) begin
		if (accept && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (accept && n_res == 2'd2) begin
			fifo_q[wr_ptr_q + PW'(1)] <= res1;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + PW'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + (accept ? (PW+1)'(n_res) : '0) - (PW+1)'(pop);
		end
	end

endmodule

`default_nettype wire
